// File: rtl/tdf_pkg.sv
`timescale 1ns / 1ps
// Package for the trial-division factorizer.
// Holds the default value width and the sequencer state type; no dependencies.
package tdf_pkg;

    localparam int VALUE_BITS_DEF = 31;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_TWOS,
        ST_CHECK,
        ST_DIV_GO,
        ST_DIV_WAIT,
        ST_FOUND,
        ST_FINAL,
        ST_FLUSH,
        ST_NONE
    } tdf_state_t;

endpackage

// File: rtl/trial_division_factorizer.sv
`timescale 1ns / 1ps
// Trial-division prime factorizer, top level: sequencer, divisor tracking, output stage.
// Depends on tdf_pkg and tdf_divider.
//
// Usage:
//   s_valid/s_ready/s_value take one integer. m_valid/m_ready carry one prime
//   factor per transfer (m_factor), ascending with multiplicity; m_last marks
//   the final factor. Inputs 0 and 1 give a single transfer with m_factor 0,
//   m_last 1 and m_no_factors 1.
//   s_ready is high only while the sequencer is idle; one integer is handled
//   at a time. Factors of two are shifted out one by one. Each odd trial
//   divisor d with d*d <= rest costs one remainder on the shared divider, and
//   one more each time it divides. Worst case, a large prime near 2^31, is
//   about 23170 divisors. One factor is held back until the next is known, so
//   m_last is exact. If the receiver stalls, the sequencer waits on a full
//   output register and resumes when the transfer completes; nothing is
//   dropped. Synchronous active-low reset returns to idle with no output
//   pending.
module trial_division_factorizer
    #(
    parameter int VALUE_BITS = tdf_pkg::VALUE_BITS_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [VALUE_BITS-1:0] s_value,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [VALUE_BITS-1:0] m_factor,
    output logic                  m_last,
    output logic                  m_no_factors
);

    import tdf_pkg::*;

    localparam int DW = (VALUE_BITS + 1) / 2 + 1;
    localparam int SW = 2 * DW;
    localparam logic [VALUE_BITS-1:0] FACTOR_TWO = VALUE_BITS'(2);
    localparam logic [DW-1:0]         FIRST_ODD  = DW'(3);

    tdf_state_t state_reg, state_next;

    logic [VALUE_BITS-1:0] rest_reg, rest_next;
    logic [DW-1:0]         d_reg, d_next;
    logic [SW-1:0]         dsq_reg, dsq_next;
    logic                  pend_valid_reg, pend_valid_next;
    logic [VALUE_BITS-1:0] pend_reg, pend_next;
    logic                  m_valid_reg, m_valid_next;
    logic [VALUE_BITS-1:0] m_factor_reg, m_factor_next;
    logic                  m_last_reg, m_last_next;
    logic                  m_no_factors_reg, m_no_factors_next;

    logic                  out_free;
    logic                  can_push;
    logic                  in_xfer;
    logic                  div_start;
    logic                  div_done;
    logic [VALUE_BITS-1:0] div_quot;
    logic [DW-1:0]         div_rem;
    logic                  loop_on;
    logic                  rest_gt1;
    logic                  push_en;
    logic [VALUE_BITS-1:0] push_val;

    assign out_free  = !m_valid_reg || m_ready;
    assign can_push  = !pend_valid_reg || out_free;
    assign s_ready   = (state_reg == ST_IDLE);
    assign in_xfer   = s_valid && s_ready;
    assign div_start = (state_reg == ST_DIV_GO);
    assign loop_on   = (dsq_reg <= SW'(rest_reg));
    assign rest_gt1  = (rest_reg > VALUE_BITS'(1));

    tdf_divider #(
        .NUM_BITS (VALUE_BITS),
        .DEN_BITS (DW)
    ) u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .num     (rest_reg),
        .den     (d_reg),
        .done    (div_done),
        .quot    (div_quot),
        .rem     (div_rem)
    );

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    state_next = (s_value < VALUE_BITS'(2)) ? ST_NONE : ST_TWOS;
                end
            end
            ST_TWOS: begin
                if (rest_reg[0]) begin
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:    state_next = loop_on ? ST_DIV_GO : ST_FINAL;
            ST_DIV_GO:   state_next = ST_DIV_WAIT;
            ST_DIV_WAIT: begin
                if (div_done) begin
                    state_next = (div_rem == '0) ? ST_FOUND : ST_CHECK;
                end
            end
            ST_FOUND: begin
                if (can_push) begin
                    state_next = ST_DIV_GO;
                end
            end
            ST_FINAL: begin
                if (!rest_gt1 || can_push) begin
                    state_next = ST_FLUSH;
                end
            end
            ST_FLUSH: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            ST_NONE: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb begin
        rest_next         = rest_reg;
        d_next            = d_reg;
        dsq_next          = dsq_reg;
        pend_valid_next   = pend_valid_reg;
        pend_next         = pend_reg;
        m_valid_next      = m_valid_reg && !m_ready;
        m_factor_next     = m_factor_reg;
        m_last_next       = m_last_reg;
        m_no_factors_next = m_no_factors_reg;
        push_en           = 1'b0;
        push_val          = rest_reg;

        unique case (state_reg)
            ST_IDLE: begin
                if (in_xfer) begin
                    rest_next = s_value;
                    d_next    = FIRST_ODD;
                    dsq_next  = SW'(FIRST_ODD) * SW'(FIRST_ODD);
                end
            end
            ST_TWOS: begin
                if (!rest_reg[0] && can_push) begin
                    push_en   = 1'b1;
                    push_val  = FACTOR_TWO;
                    rest_next = {1'b0, rest_reg[VALUE_BITS-1:1]};
                end
            end
            ST_DIV_WAIT: begin
                if (div_done && div_rem != '0) begin
                    d_next   = d_reg + DW'(2);
                    dsq_next = dsq_reg + SW'({d_reg, 2'b00}) + SW'(4);
                end
            end
            ST_FOUND: begin
                if (can_push) begin
                    push_en   = 1'b1;
                    push_val  = VALUE_BITS'(d_reg);
                    rest_next = div_quot;
                end
            end
            ST_FINAL: begin
                if (rest_gt1 && can_push) begin
                    push_en  = 1'b1;
                    push_val = rest_reg;
                end
            end
            ST_FLUSH: begin
                if (out_free) begin
                    m_valid_next      = 1'b1;
                    m_factor_next     = pend_reg;
                    m_last_next       = 1'b1;
                    m_no_factors_next = 1'b0;
                    pend_valid_next   = 1'b0;
                end
            end
            ST_NONE: begin
                if (out_free) begin
                    m_valid_next      = 1'b1;
                    m_factor_next     = '0;
                    m_last_next       = 1'b1;
                    m_no_factors_next = 1'b1;
                end
            end
            default: begin
            end
        endcase

        // held factor moves out once the next one is known
        if (push_en) begin
            if (pend_valid_reg) begin
                m_valid_next      = 1'b1;
                m_factor_next     = pend_reg;
                m_last_next       = 1'b0;
                m_no_factors_next = 1'b0;
            end
            pend_next       = push_val;
            pend_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            pend_valid_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            pend_valid_reg <= pend_valid_next;
            m_valid_reg    <= m_valid_next;
        end
        rest_reg         <= rest_next;
        d_reg            <= d_next;
        dsq_reg          <= dsq_next;
        pend_reg         <= pend_next;
        m_factor_reg     <= m_factor_next;
        m_last_reg       <= m_last_next;
        m_no_factors_reg <= m_no_factors_next;
    end

    assign m_valid      = m_valid_reg;
    assign m_factor     = m_factor_reg;
    assign m_last       = m_last_reg;
    assign m_no_factors = m_no_factors_reg;

`ifndef NO_ASSERTIONS
    a_idle_no_held: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready |-> !pend_valid_reg)
        else $error("factor still held while idle");

    a_none_is_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_no_factors) |-> (m_last && m_factor == '0))
        else $error("no-factor result not final or nonzero");

    a_factor_min: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_no_factors) |-> (m_factor >= FACTOR_TWO))
        else $error("factor below two");

    a_div_done_wait: assert property (@(posedge aclk) disable iff (!aresetn)
        div_done |-> (state_reg == ST_DIV_WAIT))
        else $error("divider finished outside wait state");

    a_div_go_once: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DIV_GO) |=> (state_reg == ST_DIV_WAIT && !div_done))
        else $error("divider start sequence broken");
`endif

endmodule

// File: rtl/tdf_divider.sv
`timescale 1ns / 1ps
// Restoring divider, one quotient bit per cycle, shared by all trial divisors.
// Standalone; start pulses load operands, done pulses when quot/rem are valid.
module tdf_divider #(
    parameter int NUM_BITS = 31,
    parameter int DEN_BITS = 17
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                start,
    input  logic [NUM_BITS-1:0] num,
    input  logic [DEN_BITS-1:0] den,
    output logic                done,
    output logic [NUM_BITS-1:0] quot,
    output logic [DEN_BITS-1:0] rem
);

    localparam int CW = (NUM_BITS > 1) ? $clog2(NUM_BITS) : 1;

    logic                busy_reg, busy_next;
    logic                done_reg, done_next;
    logic [CW-1:0]       cnt_reg, cnt_next;
    logic [NUM_BITS-1:0] num_reg, num_next;
    logic [DEN_BITS-1:0] den_reg, den_next;
    logic [DEN_BITS-1:0] rem_reg, rem_next;

    logic [DEN_BITS:0]   trial;
    logic [DEN_BITS:0]   diff;
    logic                ge;

    assign trial = {rem_reg, num_reg[NUM_BITS-1]};
    assign diff  = trial - {1'b0, den_reg};
    assign ge    = (trial >= {1'b0, den_reg});

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        num_next  = num_reg;
        den_next  = den_reg;
        rem_next  = rem_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = CW'(NUM_BITS - 1);
            num_next  = num;
            den_next  = den;
            rem_next  = '0;
        end else if (busy_reg) begin
            num_next = {num_reg[NUM_BITS-2:0], ge};
            rem_next = ge ? diff[DEN_BITS-1:0] : trial[DEN_BITS-1:0];
            cnt_next = cnt_reg - CW'(1);
            if (cnt_reg == '0) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
        cnt_reg <= cnt_next;
        num_reg <= num_next;
        den_reg <= den_next;
        rem_reg <= rem_next;
    end

    assign done = done_reg;
    assign quot = num_reg;
    assign rem  = rem_reg;

endmodule

// File: bench/tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for trial_division_factorizer: sends integers, predicts their
// prime factors in software and checks every factor transfer in order.
// Depends on tdf_pkg and the RTL top level.
module tb;
    import tdf_pkg::*;

    localparam int VB           = VALUE_BITS_DEF;
    localparam int HOLD_CYCLES  = 400;
    localparam int STALL_LIMIT  = 3000000;
    localparam int DRAIN_CYCLES = 100;
    localparam int RANDOM_ITEMS = 100;

    typedef struct packed {
        logic [VB-1:0] factor;
        logic          last;
        logic          no_factors;
    } factor_xfer_t;

    logic          aclk;
    logic          aresetn = 1'b0;
    logic          s_valid = 1'b0;
    logic          s_ready;
    logic [VB-1:0] s_value = '0;
    logic          m_valid;
    logic          m_ready = 1'b0;
    logic [VB-1:0] m_factor;
    logic          m_last;
    logic          m_no_factors;

    logic [VB-1:0] values_to_send[$];
    factor_xfer_t  factors_due[$];
    factor_xfer_t  due;
    int unsigned   small_primes[25] = '{2, 3, 5, 7, 11, 13, 17, 19, 23, 29, 31, 37, 41,
                                        43, 47, 53, 59, 61, 67, 71, 73, 79, 83, 89, 97};
    int            n_total = 0;
    int            n_sent = 0;
    int            n_recv = 0;
    int            errors = 0;
    int            hold_left = 0;
    int            quiet_cycles = 0;
    bit            hold_done = 1'b0;

    trial_division_factorizer #(
        .VALUE_BITS(VB)
    ) uut (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_value(s_value),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_factor(m_factor),
        .m_last(m_last),
        .m_no_factors(m_no_factors)
    );

    // Queues the factor transfers one integer must produce.
    task automatic factorize(input logic [VB-1:0] v);
        longint unsigned rest;
        longint unsigned d;
        longint unsigned primes[$];
        rest = v;
        if (rest < 2) begin
            factors_due.insert(factors_due.size(), {{VB{1'b0}}, 1'b1, 1'b1});
            return;
        end
        while (rest[0] == 1'b0) begin
            primes.insert(primes.size(), 2);
            rest = rest >> 1;
        end
        for (d = 3; d <= rest / d; d += 2) begin
            while (rest % d == 0) begin
                primes.insert(primes.size(), d);
                rest = rest / d;
            end
        end
        if (rest > 1) begin
            primes.insert(primes.size(), rest);
        end
        foreach (primes[i]) begin
            factors_due.insert(factors_due.size(),
                               {VB'(primes[i]), (i == primes.size() - 1), 1'b0});
        end
    endtask

    // Mostly cheap values: trial cost grows with the square root of the largest cofactor.
    function automatic logic [VB-1:0] random_value();
        longint unsigned v;
        longint unsigned lim;
        longint unsigned mask;
        longint unsigned p;
        mask = (64'd1 << VB) - 1;
        case ($urandom_range(9))
            0, 1, 2: begin
                v = $urandom_range(200);
            end
            3, 4: begin
                lim = (64'd1 << $urandom_range(VB, 12)) - 1;
                v = 1;
                repeat (40) begin
                    p = small_primes[$urandom_range(24)];
                    if (v * p <= lim) begin
                        v = v * p;
                    end
                end
            end
            5, 6: begin
                v = (($urandom_range(4095, 1) | 1) << $urandom_range(VB - 1)) & mask;
            end
            7, 8: begin
                v = $urandom & ((64'd1 << $urandom_range(16, 2)) - 1);
            end
            default: begin
                v = (($urandom_range(30000, 1000) | 1) << $urandom_range(16)) & mask;
            end
        endcase
        return v[VB-1:0];
    endfunction

    initial begin
        values_to_send = '{0, 1, 2, 3, 4, 9, 25, 49, 6, 315, 63001, 65521, 131042,
                           65536, 1073741824, 1162261467, 2147483646, 2146992128,
                           2147483647};
        repeat (RANDOM_ITEMS) values_to_send.insert(values_to_send.size(), random_value());
        n_total = values_to_send.size();
    end

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Driver: leaves a gap before about 8 in 100 items, none while items 40 to 69 go out.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || s_ready) begin
            if (s_valid) begin
                factorize(s_value);
                n_sent++;
            end
            if (values_to_send.size() > 0 &&
                ((n_sent >= 40 && n_sent < 70) || $urandom_range(99) >= 8)) begin
                s_valid <= 1'b1;
                s_value <= values_to_send.pop_front();
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // Monitor: checks each factor transfer, stalls at random, holds off once for a long stretch.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                n_recv++;
                if (factors_due.size() == 0) begin
                    $display("%0t: unexpected transfer: factor %0d last %0b no_factors %0b",
                             $time, m_factor, m_last, m_no_factors);
                    errors++;
                end else begin
                    due = factors_due.pop_front();
                    if (m_factor !== due.factor) begin
                        $display("%0t: factor: expected %0d, got %0d",
                                 $time, due.factor, m_factor);
                        errors++;
                    end
                    if (m_last !== due.last) begin
                        $display("%0t: last: expected %0b, got %0b", $time, due.last, m_last);
                        errors++;
                    end
                    if (m_no_factors !== due.no_factors) begin
                        $display("%0t: no_factors: expected %0b, got %0b",
                                 $time, due.no_factors, m_no_factors);
                        errors++;
                    end
                end
            end
            if (!hold_done && n_recv >= 25) begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= (n_recv >= 100 && n_recv < 200) || $urandom_range(99) >= 8;
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles = 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("status: fail");
            $finish;
        end else begin
            quiet_cycles++;
        end
    end

    initial begin
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        wait (n_total > 0 && n_sent == n_total && factors_due.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (errors == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

// File: filelist.f
rtl/tdf_pkg.sv
rtl/tdf_divider.sv
rtl/trial_division_factorizer.sv
bench/tb.sv
